// ===== hw/rtl/weighted_voronoi_balance_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance unit assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_VORONOI_BALANCE_UNIT_DEFINES_SVH
`define WEIGHTED_VORONOI_BALANCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WVB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("weighted voronoi balance check failed");

// Next-cycle implication, disabled during reset.
`define WVB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("weighted voronoi balance check failed");

`endif

// ===== hw/rtl/wvb_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance package
// Widths, codes, state encoding and memory entry layouts of the block.
// ----------------------------------------------------------------------------
package wvb_pkg;

  localparam int NCENTERS     = 16;
  localparam int IDX_W        = 4;
  localparam int NUM_CTR_W    = 5;
  localparam int COORD_BITS   = 10;
  localparam int FRAC_BITS    = 6;
  localparam int POS_W        = 16;
  localparam int WEIGHT_W     = 16;
  localparam int FACTOR_W     = 16;
  localparam int FACTOR_SHIFT = 14;
  localparam int COUNT_BITS   = 24;
  localparam int SUM_W        = 34;
  localparam int DIST_W       = 34;
  localparam int TOTAL_W      = 28;
  localparam int LIM_W        = 45;
  localparam int CN_W         = 29;
  localparam int NUM_W        = 41;
  localparam int DEN_W        = 25;
  localparam int QUOT_W       = 16;
  localparam int LANES        = 3;

  localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = 16'd256;
  localparam logic [FACTOR_W-1:0]   FACTOR_ONE = 16'd16384;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic                  KIND_CELL   = 1'b0;
  localparam logic                  KIND_CENTER = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_CLASSIFY,
    OP_UPDATE,
    OP_NONE
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_NUM_CENTERS,
    CFG_TOLERANCE,
    CFG_GROW,
    CFG_SHRINK
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CL_SCAN,
    ST_CL_ACC_RD,
    ST_CL_ACC_WR,
    ST_UP_SUM,
    ST_UP_LIM,
    ST_UP_RD,
    ST_UP_PREP,
    ST_UP_DIV
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [POS_W-1:0]    z;
    logic [WEIGHT_W-1:0] weight;
  } center_t;

  typedef struct packed {
    logic [SUM_W-1:0]      sum_x;
    logic [SUM_W-1:0]      sum_y;
    logic [SUM_W-1:0]      sum_z;
    logic [COUNT_BITS-1:0] count;
  } acc_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

// ===== hw/rtl/wvb_if.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wvb_item_if import wvb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [IDX_W-1:0]      center_index;
  logic [COORD_BITS-1:0] cell_x;
  logic [COORD_BITS-1:0] cell_y;
  logic [COORD_BITS-1:0] cell_z;
  logic [POS_W-1:0]      load_x;
  logic [POS_W-1:0]      load_y;
  logic [POS_W-1:0]      load_z;
  logic [WEIGHT_W-1:0]   load_weight;

  modport source (
    output valid, opcode, center_index, cell_x, cell_y, cell_z,
           load_x, load_y, load_z, load_weight,
    input  ready
  );
  modport sink (
    input  valid, opcode, center_index, cell_x, cell_y, cell_z,
           load_x, load_y, load_z, load_weight,
    output ready
  );
endinterface

interface wvb_result_if import wvb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [IDX_W-1:0]      which_center;
  logic [POS_W-1:0]      new_x;
  logic [POS_W-1:0]      new_y;
  logic [POS_W-1:0]      new_z;
  logic [WEIGHT_W-1:0]   new_weight;
  logic [COUNT_BITS-1:0] cells_owned;
  logic                  last;

  modport source (
    output valid, result_kind, which_center, new_x, new_y, new_z,
           new_weight, cells_owned, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, which_center, new_x, new_y, new_z,
           new_weight, cells_owned, last,
    output ready
  );
endinterface

// ===== hw/rtl/wvb_ram.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module wvb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/wvb_div.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance centroid divider
// Three restoring division lanes sharing one divisor, one quotient bit per
// cycle, with the quotient saturated to sixteen bits.
// ----------------------------------------------------------------------------
module wvb_div
  import wvb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic              done,
  output logic [QUOT_W-1:0] quot [LANES]
);

  localparam int STEP_W = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem [LANES];
  logic [QUOT_W-1:0] q   [LANES];
  logic              sat [LANES];
  logic [NUM_W-1:0]  dsh;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= STEP_W'(QUOT_W - 1);
    end else if (busy) begin
      step <= step - STEP_W'(1);
      if (step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsh <= {{(NUM_W - DEN_W - QUOT_W + 1){1'b0}}, den, {(QUOT_W - 1){1'b0}}};
      for (int l = 0; l < LANES; l++) begin
        rem[l] <= num[l];
        q[l]   <= '0;
        sat[l] <= num[l] >= {den, {QUOT_W{1'b0}}};
      end
    end else if (busy) begin
      dsh <= dsh >> 1;
      for (int l = 0; l < LANES; l++) begin
        if (rem[l] >= dsh) begin
          rem[l] <= rem[l] - dsh;
          q[l]   <= {q[l][QUOT_W-2:0], 1'b1};
        end else begin
          q[l]   <= {q[l][QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot[l] = sat[l] ? {QUOT_W{1'b1}} : q[l];
    end
  end

endmodule

// ===== hw/rtl/wvb_argmin.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance nearest-center search
// Four-stage pipeline taking one center per cycle: distance terms, squares,
// sum, then a cross-multiplied compare of distance over weight.
// ----------------------------------------------------------------------------
module wvb_argmin
  import wvb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  scan_tag_t        tag,
  input  logic [POS_W-1:0] px,
  input  logic [POS_W-1:0] py,
  input  logic [POS_W-1:0] pz,
  input  center_t          cen,
  output logic             done,
  output logic [IDX_W-1:0] best
);

  scan_tag_t             t1, t2, t3;
  logic [POS_W-1:0]      dx, dy, dz;
  logic [2*POS_W-1:0]    sx, sy, sz;
  logic [DIST_W-1:0]     d3, bd;
  logic [WEIGHT_W-1:0]   w1, w2, w3, bw;
  logic [DIST_W+WEIGHT_W-1:0] lhs, rhs;
  logic                  take;

  assign lhs  = (DIST_W+WEIGHT_W)'(d3) * (DIST_W+WEIGHT_W)'(bw);
  assign rhs  = (DIST_W+WEIGHT_W)'(bd) * (DIST_W+WEIGHT_W)'(w3);
  assign take = t3.first || (lhs < rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      t1   <= '0;
      t2   <= '0;
      t3   <= '0;
      done <= 1'b0;
    end else begin
      t1   <= tag;
      t2   <= t1;
      t3   <= t2;
      done <= t3.valid && t3.last;
    end
  end

  always_ff @(posedge clk) begin
    dx <= (px > cen.x) ? px - cen.x : cen.x - px;
    dy <= (py > cen.y) ? py - cen.y : cen.y - py;
    dz <= (pz > cen.z) ? pz - cen.z : cen.z - pz;
    w1 <= cen.weight;
    sx <= (2*POS_W)'(dx) * (2*POS_W)'(dx);
    sy <= (2*POS_W)'(dy) * (2*POS_W)'(dy);
    sz <= (2*POS_W)'(dz) * (2*POS_W)'(dz);
    w2 <= w1;
    d3 <= DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    w3 <= w2;
    if (t3.valid && take) begin
      bd   <= d3;
      bw   <= w3;
      best <= t3.idx;
    end
  end

endmodule

// ===== hw/rtl/weighted_voronoi_balance_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted Voronoi balance unit
// Weighted k-means cell assignment with centroid update and weight biasing.
// ----------------------------------------------------------------------------
// A load writes the center memory directly. A classify reads the center
// memory one center per cycle into a four-stage distance pipeline, followed
// by a read-modify-write of the winner's accumulators. An update makes a
// count pass over the accumulator memory, then one centroid division per
// center in the 16-step bit-serial centroid divider. Results wait in an
// output register, so the next item is taken while one is still pending.
// Reset needs no clearing pass: per-entry valid bits give the reset weight
// and zero accumulators.
// ----------------------------------------------------------------------------
`include "weighted_voronoi_balance_unit_defines.svh"

module weighted_voronoi_balance_unit
  import wvb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  wvb_item_if.sink     item,
  wvb_result_if.source result
);

  state_t                 state, state_next;
  logic [NUM_CTR_W-1:0]   num_centers;
  logic [15:0]            balance_tolerance;
  logic [15:0]            grow_factor;
  logic [14:0]            shrink_factor;
  logic [NUM_CTR_W-1:0]   n_act, nm1;

  logic [NCENTERS-1:0]    w_valid, acc_valid;
  logic [COORD_BITS-1:0]  cur_cell_x, cur_cell_y, cur_cell_z;
  logic [NUM_CTR_W-1:0]   sc;
  logic                   rd_v, rd_last;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       ui;
  logic                   ui_last;

  logic                   cen_we, acc_we;
  logic [IDX_W-1:0]       cen_waddr, cen_raddr, acc_raddr, cen_ridx, acc_ridx;
  center_t                cen_wdata, cen_rdata, cen_eff, load_entry;
  acc_t                   acc_wdata, acc_rdata, acc_eff;

  logic                   item_accept, out_free, emit, div_start;
  scan_tag_t              tag;
  logic                   am_done;
  logic [IDX_W-1:0]       best;

  logic [TOTAL_W-1:0]     total;
  logic [LIM_W-1:0]       lo_lim, hi_lim, cn_sh;
  logic [16:0]            tol_lo, tol_hi;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic [WEIGHT_W-1:0]    wcur;
  logic [CN_W-1:0]        cn;
  logic                   grow_sel, shrink_sel;
  logic [FACTOR_W-1:0]    factor;
  logic [2*WEIGHT_W-1:0]  wprod;
  logic [2*WEIGHT_W:0]    wsum;
  logic [2*WEIGHT_W-FACTOR_SHIFT:0] wsh;
  logic [WEIGHT_W-1:0]    wnew;

  logic [DEN_W-1:0]       den_w;
  logic [NUM_W-1:0]       div_num [LANES];
  logic                   div_busy, div_done;
  logic [QUOT_W-1:0]      div_q [LANES];

  assign n_act = (num_centers == '0) ? NUM_CTR_W'(1) :
                 (num_centers > NUM_CTR_W'(NCENTERS)) ? NUM_CTR_W'(NCENTERS) : num_centers;
  assign nm1     = n_act - NUM_CTR_W'(1);
  assign rd_last = {1'b0, rd_idx} == nm1;
  assign ui_last = {1'b0, ui} == nm1;

  assign item.ready  = state == ST_IDLE;
  assign item_accept = item.valid && item.ready;
  assign out_free    = !result.valid || result.ready;

  assign cen_eff.x      = cen_rdata.x;
  assign cen_eff.y      = cen_rdata.y;
  assign cen_eff.z      = cen_rdata.z;
  assign cen_eff.weight = w_valid[cen_ridx] ? cen_rdata.weight : WEIGHT_ONE;
  assign acc_eff        = acc_valid[acc_ridx] ? acc_rdata : '0;

  assign load_entry.x      = item.load_x;
  assign load_entry.y      = item.load_y;
  assign load_entry.z      = item.load_z;
  assign load_entry.weight = (item.load_weight == '0) ? WEIGHT_W'(1) : item.load_weight;

  assign cen_raddr = (state == ST_CL_SCAN) ? sc[IDX_W-1:0] : ui;
  assign acc_raddr = (state == ST_CL_ACC_RD || state == ST_CL_ACC_WR) ? best :
                     (state == ST_UP_SUM) ? sc[IDX_W-1:0] : ui;

  assign acc_wdata.count = acc_eff.count + COUNT_BITS'(1);
  assign acc_wdata.sum_x = acc_eff.sum_x + SUM_W'(cur_cell_x);
  assign acc_wdata.sum_y = acc_eff.sum_y + SUM_W'(cur_cell_y);
  assign acc_wdata.sum_z = acc_eff.sum_z + SUM_W'(cur_cell_z);

  assign den_w      = DEN_W'(acc_eff.count) + DEN_W'(1);
  assign div_num[0] = NUM_W'(cen_eff.x) + (NUM_W'(acc_eff.sum_x) << FRAC_BITS)
                    + NUM_W'(den_w >> 1);
  assign div_num[1] = NUM_W'(cen_eff.y) + (NUM_W'(acc_eff.sum_y) << FRAC_BITS)
                    + NUM_W'(den_w >> 1);
  assign div_num[2] = NUM_W'(cen_eff.z) + (NUM_W'(acc_eff.sum_z) << FRAC_BITS)
                    + NUM_W'(den_w >> 1);

  assign tol_lo = 17'h10000 - {1'b0, balance_tolerance};
  assign tol_hi = 17'h10000 + {1'b0, balance_tolerance};
  assign cn_sh  = {cn, 16'h0000};
  assign factor = grow_sel ? grow_factor : shrink_sel ? {1'b0, shrink_factor} : FACTOR_ONE;
  assign wsum   = {1'b0, wprod} + (2*WEIGHT_W+1)'(1 << (FACTOR_SHIFT - 1));
  assign wsh    = wsum[2*WEIGHT_W:FACTOR_SHIFT];
  assign wnew   = (wsh > {{(2*WEIGHT_W-FACTOR_SHIFT+1-WEIGHT_W){1'b0}}, {WEIGHT_W{1'b1}}}) ?
                  {WEIGHT_W{1'b1}} :
                  (wsh == '0) ? WEIGHT_W'(1) : wsh[WEIGHT_W-1:0];

  assign tag.valid = rd_v && (state == ST_CL_SCAN);
  assign tag.first = rd_idx == '0;
  assign tag.last  = rd_last;
  assign tag.idx   = rd_idx;

  wvb_ram #(.WIDTH($bits(center_t)), .DEPTH(NCENTERS)) u_center_ram (
    .clk   (clk),
    .we    (cen_we),
    .waddr (cen_waddr),
    .wdata (cen_wdata),
    .raddr (cen_raddr),
    .rdata (cen_rdata)
  );

  wvb_ram #(.WIDTH($bits(acc_t)), .DEPTH(NCENTERS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (best),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  wvb_argmin u_argmin (
    .clk  (clk),
    .rst  (rst),
    .tag  (tag),
    .px   ({cur_cell_x, {FRAC_BITS{1'b0}}}),
    .py   ({cur_cell_y, {FRAC_BITS{1'b0}}}),
    .pz   ({cur_cell_z, {FRAC_BITS{1'b0}}}),
    .cen  (cen_eff),
    .done (am_done),
    .best (best)
  );

  wvb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den_w),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_next = state;
    cen_we     = 1'b0;
    cen_waddr  = item.center_index;
    cen_wdata  = load_entry;
    acc_we     = 1'b0;
    emit       = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_accept) begin
          case (opcode_t'(item.opcode))
            OP_LOAD:     cen_we = 1'b1;
            OP_CLASSIFY: state_next = ST_CL_SCAN;
            OP_UPDATE:   state_next = ST_UP_SUM;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_CL_SCAN: begin
        if (am_done) begin
          state_next = ST_CL_ACC_RD;
        end
      end
      ST_CL_ACC_RD: state_next = ST_CL_ACC_WR;
      ST_CL_ACC_WR: begin
        if (out_free) begin
          emit       = 1'b1;
          acc_we     = acc_eff.count != COUNT_MAX;
          state_next = ST_IDLE;
        end
      end
      ST_UP_SUM: begin
        if (rd_v && rd_last) begin
          state_next = ST_UP_LIM;
        end
      end
      ST_UP_LIM:  state_next = ST_UP_RD;
      ST_UP_RD:   state_next = ST_UP_PREP;
      ST_UP_PREP: begin
        div_start  = 1'b1;
        state_next = ST_UP_DIV;
      end
      ST_UP_DIV: begin
        if (div_done && out_free) begin
          emit             = 1'b1;
          cen_we           = 1'b1;
          cen_waddr        = ui;
          cen_wdata.x      = div_q[0];
          cen_wdata.y      = div_q[1];
          cen_wdata.z      = div_q[2];
          cen_wdata.weight = wnew;
          state_next       = ui_last ? ST_IDLE : ST_UP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      num_centers       <= NUM_CTR_W'(16);
      balance_tolerance <= 16'd3277;
      grow_factor       <= 16'd16548;
      shrink_factor     <= 15'd16222;
      w_valid           <= '0;
      acc_valid         <= '0;
      sc                <= '0;
      rd_v              <= 1'b0;
      ui                <= '0;
      result.valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_NUM_CENTERS: num_centers       <= cfg_data[NUM_CTR_W-1:0];
          CFG_TOLERANCE:   balance_tolerance <= cfg_data;
          CFG_GROW:        grow_factor       <= cfg_data;
          CFG_SHRINK:      shrink_factor     <= cfg_data[14:0];
          default:         num_centers       <= num_centers;
        endcase
      end
      if (cen_we) begin
        w_valid[cen_waddr] <= 1'b1;
      end
      if (acc_we) begin
        acc_valid[best] <= 1'b1;
      end
      if (emit && state == ST_UP_DIV) begin
        acc_valid[ui] <= 1'b0;
      end
      if (item_accept) begin
        sc <= '0;
      end else if ((state == ST_CL_SCAN || state == ST_UP_SUM) && sc < n_act) begin
        sc <= sc + NUM_CTR_W'(1);
      end
      rd_v <= (state == ST_CL_SCAN || state == ST_UP_SUM) && sc < n_act;
      if (state == ST_UP_LIM) begin
        ui <= '0;
      end else if (emit && state == ST_UP_DIV) begin
        ui <= ui + IDX_W'(1);
      end
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cen_ridx <= cen_raddr;
    acc_ridx <= acc_raddr;
    rd_idx   <= sc[IDX_W-1:0];
    if (item_accept) begin
      cur_cell_x <= item.cell_x;
      cur_cell_y <= item.cell_y;
      cur_cell_z <= item.cell_z;
      total      <= '0;
    end else if (state == ST_UP_SUM && rd_v) begin
      total <= total + TOTAL_W'(acc_eff.count);
    end
    if (state == ST_UP_LIM) begin
      lo_lim <= LIM_W'(tol_lo) * LIM_W'(total);
      hi_lim <= LIM_W'(tol_hi) * LIM_W'(total);
    end
    if (state == ST_UP_PREP) begin
      cnt_r <= acc_eff.count;
      wcur  <= cen_eff.weight;
      cn    <= CN_W'(acc_eff.count) * CN_W'(n_act);
    end
    if (state == ST_UP_DIV) begin
      grow_sel   <= cn_sh < lo_lim;
      shrink_sel <= cn_sh > hi_lim;
      wprod      <= (2*WEIGHT_W)'(wcur) * (2*WEIGHT_W)'(factor);
    end
    if (emit) begin
      if (state == ST_UP_DIV) begin
        result.result_kind  <= KIND_CENTER;
        result.which_center <= ui;
        result.new_x        <= div_q[0];
        result.new_y        <= div_q[1];
        result.new_z        <= div_q[2];
        result.new_weight   <= wnew;
        result.cells_owned  <= cnt_r;
        result.last         <= ui_last;
      end else begin
        result.result_kind  <= KIND_CELL;
        result.which_center <= best;
        result.new_x        <= '0;
        result.new_y        <= '0;
        result.new_z        <= '0;
        result.new_weight   <= '0;
        result.cells_owned  <= '0;
        result.last         <= 1'b0;
      end
    end
  end

  `WVB_ASSERT_IMP(a_last_is_update, clk, rst, result.valid && result.last, result.result_kind)
  `WVB_ASSERT_IMP(a_weight_nonzero, clk, rst, result.valid && result.result_kind, result.new_weight != '0)
  `WVB_ASSERT_IMP(a_div_in_div_state, clk, rst, div_busy, state == ST_UP_DIV)
  `WVB_ASSERT_NXT(a_update_emits, clk, rst, state == ST_UP_DIV && div_done && out_free, result.valid)

endmodule
